### hw/rtl/graph_depth_first_trace_unit_macros.svh
// assertion macros for the depth-first trace unit
// no dependencies; included by the top level only
`ifndef GRAPH_DEPTH_FIRST_TRACE_UNIT_MACROS_SVH
`define GRAPH_DEPTH_FIRST_TRACE_UNIT_MACROS_SVH

// same-cycle implication check
`define GDFT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdft: same-cycle check failed");

// next-cycle implication check
`define GDFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdft: next-cycle check failed");

`endif

### hw/rtl/gdft_pkg.sv
// shared types, step codes and the control store of the depth-first trace unit
// no dependencies
package gdft_pkg;

   localparam int unsigned VERTEX_W             = 4;
   localparam int unsigned VERTEX_COUNT_DEF     = 16;
   localparam int unsigned EDGES_PER_VERTEX_DEF = 16;
   localparam int unsigned PC_W                 = 4;

   localparam logic KIND_LINK  = 1'b0;
   localparam logic KIND_TRACE = 1'b1;

   // result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_DROP = 1'b1;

   typedef logic [PC_W-1:0] step_type;

   // program step addresses
   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_DISPATCH = 4'd1;
   localparam step_type STEP_LINK     = 4'd2;
   localparam step_type STEP_INIT     = 4'd3;
   localparam step_type STEP_POP      = 4'd4;
   localparam step_type STEP_LOAD     = 4'd5;
   localparam step_type STEP_SCAN     = 4'd6;
   localparam step_type STEP_VISIT    = 4'd7;
   localparam step_type STEP_EMIT     = 4'd8;
   localparam step_type STEP_BAD      = 4'd9;

   typedef struct packed {
      logic                kind;
      logic [VERTEX_W-1:0] source_vertex;
      logic [VERTEX_W-1:0] target_vertex;
      logic [VERTEX_W-1:0] start_vertex;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] visited_vertex;
      logic                status;
      logic                last;
   } rsp_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LINK,
      ACT_INIT,
      ACT_POP,
      ACT_LOAD,
      ACT_SCAN,
      ACT_VISIT,
      ACT_EMIT_CUR,
      ACT_EMIT_START
   } action_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_TRACE,
      COND_BAD_START,
      COND_CNT_ZERO,
      COND_STACK_LIVE
   } cond_type;

   // one control word: datapath action, jump condition and target,
   // and whether a failed jump ends the program
   typedef struct packed {
      action_type action;
      cond_type   cond;
      step_type   target;
      logic       end_else;
   } uword_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic is_trace;
      logic start_bad;
      logic cnt_zero;
      logic stack_live;
   } flags_type;

   // control store
   function automatic uword_type gdft_rom(step_type step);
      uword_type w;
      unique case (step)
         STEP_IDLE:     w = '{ACT_NONE,       COND_NO_START,   STEP_IDLE, 1'b0};
         STEP_DISPATCH: w = '{ACT_NONE,       COND_TRACE,      STEP_INIT, 1'b0};
         STEP_LINK:     w = '{ACT_LINK,       COND_ALWAYS,     STEP_IDLE, 1'b0};
         STEP_INIT:     w = '{ACT_INIT,       COND_BAD_START,  STEP_BAD,  1'b0};
         STEP_POP:      w = '{ACT_POP,        COND_NEVER,      STEP_IDLE, 1'b0};
         STEP_LOAD:     w = '{ACT_LOAD,       COND_NEVER,      STEP_IDLE, 1'b0};
         STEP_SCAN:     w = '{ACT_SCAN,       COND_CNT_ZERO,   STEP_EMIT, 1'b0};
         STEP_VISIT:    w = '{ACT_VISIT,      COND_ALWAYS,     STEP_SCAN, 1'b0};
         STEP_EMIT:     w = '{ACT_EMIT_CUR,   COND_STACK_LIVE, STEP_POP,  1'b1};
         STEP_BAD:      w = '{ACT_EMIT_START, COND_ALWAYS,     STEP_IDLE, 1'b0};
         default:       w = '{ACT_NONE,       COND_ALWAYS,     STEP_IDLE, 1'b0};
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/gdft_seq.sv
// microcode sequencer: step counter, control store lookup and jump logic
// depends on gdft_pkg
module gdft_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  gdft_pkg::flags_type    flags,
   output gdft_pkg::action_type   action,
   output logic                   busy
);
   import gdft_pkg::*;

   step_type  pc_ff;
   step_type  pc_in;
   uword_type word;
   logic      take;

   assign word = gdft_rom(pc_ff);

   // jump condition
   always_comb begin
      unique case (word.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_NO_START:   take = !start;
         COND_TRACE:      take = flags.is_trace;
         COND_BAD_START:  take = flags.start_bad;
         COND_CNT_ZERO:   take = flags.cnt_zero;
         COND_STACK_LIVE: take = flags.stack_live;
         default:         take = 1'b1;
      endcase
   end

   // next step
   always_comb begin
      priority if (take) begin
         pc_in = word.target;
      end else if (word.end_else) begin
         pc_in = STEP_IDLE;
      end else begin
         pc_in = pc_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign action = word.action;
   assign busy   = (pc_ff != STEP_IDLE);

endmodule

### hw/rtl/gdft_path.sv
// datapath: edge store, edge counts, visited marks, walk stack and result register
// depends on gdft_pkg
module gdft_path #(
   parameter int unsigned VERTEX_COUNT     = gdft_pkg::VERTEX_COUNT_DEF,
   parameter int unsigned EDGES_PER_VERTEX = gdft_pkg::EDGES_PER_VERTEX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  gdft_pkg::req_type     req_data,
   input  gdft_pkg::action_type  action,
   output gdft_pkg::flags_type   flags,
   output logic                  rsp_valid,
   output gdft_pkg::rsp_type     rsp_data
);
   import gdft_pkg::*;

   localparam int unsigned VIW   = $clog2(VERTEX_COUNT);
   localparam int unsigned SIW   = $clog2(VERTEX_COUNT);
   localparam int unsigned SW    = $clog2(VERTEX_COUNT + 1);
   localparam int unsigned CW    = $clog2(EDGES_PER_VERTEX + 1);
   localparam int unsigned DEPTH = VERTEX_COUNT * EDGES_PER_VERTEX;
   localparam int unsigned AW    = $clog2(DEPTH);

   req_type             req_ff;
   logic [CW-1:0]       counts_ff [VERTEX_COUNT];
   logic [VERTEX_COUNT-1:0] visited_ff;
   logic [SW-1:0]       sp_ff;
   logic [CW-1:0]       cnt_ff;
   logic [VERTEX_W-1:0] cur_ff;
   logic [VERTEX_W-1:0] edge_mem [DEPTH];
   logic [VERTEX_W-1:0] edge_rd_ff;
   logic [VERTEX_W-1:0] stack_mem [VERTEX_COUNT];
   logic [VERTEX_W-1:0] stack_rd_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [VIW-1:0]      src_idx;
   logic [VIW-1:0]      start_idx;
   logic [VIW-1:0]      cur_idx;
   logic [VIW-1:0]      tgt_idx;
   logic [VIW-1:0]      load_idx;
   logic                src_ok;
   logic                dst_ok;
   logic                start_ok;
   logic [CW-1:0]       src_count;
   logic                link_ok;
   logic [AW-1:0]       link_addr;
   logic [CW-1:0]       scan_idx;
   logic [AW-1:0]       scan_addr;
   logic                tgt_new;
   logic [SIW-1:0]      pop_idx;
   logic                stack_we;
   logic [SIW-1:0]      stack_waddr;
   logic [VERTEX_W-1:0] stack_wdata;

   // link decode
   assign src_idx   = VIW'(req_ff.source_vertex);
   assign src_ok    = (32'(req_ff.source_vertex) < VERTEX_COUNT);
   assign dst_ok    = (32'(req_ff.target_vertex) < VERTEX_COUNT);
   assign src_count = counts_ff[src_idx];
   assign link_ok   = src_ok && dst_ok && (src_count != CW'(EDGES_PER_VERTEX));
   assign link_addr = AW'(src_idx) * AW'(EDGES_PER_VERTEX) + AW'(src_count);

   // trace decode
   assign start_idx = VIW'(req_ff.start_vertex);
   assign start_ok  = (32'(req_ff.start_vertex) < VERTEX_COUNT);
   assign cur_idx   = VIW'(cur_ff);
   assign load_idx  = VIW'(stack_rd_ff);
   assign scan_idx  = cnt_ff - CW'(1);
   assign scan_addr = AW'(cur_idx) * AW'(EDGES_PER_VERTEX) + AW'(scan_idx);
   assign tgt_idx   = VIW'(edge_rd_ff);
   assign tgt_new   = (32'(edge_rd_ff) < VERTEX_COUNT) && !visited_ff[tgt_idx];
   assign pop_idx   = SIW'(sp_ff - SW'(1));

   // stack write port: seed on init, push on a fresh neighbour
   always_comb begin
      stack_we    = 1'b0;
      stack_waddr = '0;
      stack_wdata = req_ff.start_vertex;
      unique case (action)
         ACT_INIT: begin
            stack_we = start_ok;
         end
         ACT_VISIT: begin
            stack_we    = tgt_new;
            stack_waddr = SIW'(sp_ff);
            stack_wdata = edge_rd_ff;
         end
         default: begin
            stack_we = 1'b0;
         end
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // edge store, registered read
   always_ff @(posedge clock) begin
      if (action == ACT_LINK && link_ok) begin
         edge_mem[link_addr] <= req_ff.target_vertex;
      end
      if (action == ACT_SCAN) begin
         edge_rd_ff <= edge_mem[scan_addr];
      end
   end

   // walk stack, registered read
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (action == ACT_POP) begin
         stack_rd_ff <= stack_mem[pop_idx];
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (action == ACT_LOAD) begin
         cur_ff <= stack_rd_ff;
         cnt_ff <= counts_ff[load_idx];
      end else if (action == ACT_SCAN && cnt_ff != '0) begin
         cnt_ff <= scan_idx;
      end
   end

   // edge counts, visited marks and stack depth
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VERTEX_COUNT; i++) begin
            counts_ff[i] <= '0;
         end
         visited_ff <= '0;
         sp_ff      <= '0;
      end else begin
         unique case (action)
            ACT_LINK: begin
               if (link_ok) begin
                  counts_ff[src_idx] <= src_count + CW'(1);
               end
            end
            ACT_INIT: begin
               // marks cleared with only the start vertex set
               if (start_ok) begin
                  visited_ff <= VERTEX_COUNT'(1) << start_idx;
                  sp_ff      <= SW'(1);
               end
            end
            ACT_POP: begin
               sp_ff <= sp_ff - SW'(1);
            end
            ACT_VISIT: begin
               if (tgt_new) begin
                  visited_ff[tgt_idx] <= 1'b1;
                  sp_ff               <= sp_ff + SW'(1);
               end
            end
            default: begin
               sp_ff <= sp_ff;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (action == ACT_LINK) || (action == ACT_EMIT_CUR) ||
                         (action == ACT_EMIT_START);
      end
      unique case (action)
         ACT_LINK:       rsp_ff <= '{'0, (link_ok ? STATUS_OK : STATUS_DROP), 1'b1};
         ACT_EMIT_CUR:   rsp_ff <= '{cur_ff, STATUS_OK, (sp_ff == '0)};
         ACT_EMIT_START: rsp_ff <= '{req_ff.start_vertex, STATUS_OK, 1'b1};
         default:        rsp_ff <= rsp_ff;
      endcase
   end

   assign flags.is_trace   = (req_ff.kind == KIND_TRACE);
   assign flags.start_bad  = !start_ok;
   assign flags.cnt_zero   = (cnt_ff == '0);
   assign flags.stack_live = (sp_ff != '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/graph_depth_first_trace_unit.sv
// link: dispatch, then link step registers the result; busy low with it; one link at a time
// trace: dispatch and init set up; per popped vertex: pop, load, scan and visit per stored edge,
// then a last scan and the emit, the result strobing at the end of that vertex's edge scan
// edge-store reads are never back to back; start-vertex out of range: one result
// synchronous reset clears edge counts, visited marks, stack depth and the step counter
// results cannot be stalled; each strobes for exactly one cycle
`include "graph_depth_first_trace_unit_macros.svh"

module graph_depth_first_trace_unit #(
   parameter int unsigned VERTEX_COUNT     = gdft_pkg::VERTEX_COUNT_DEF,
   parameter int unsigned EDGES_PER_VERTEX = gdft_pkg::EDGES_PER_VERTEX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gdft_pkg::req_type  req_data,
   output logic               rsp_valid,
   output gdft_pkg::rsp_type  rsp_data
);
   import gdft_pkg::*;

   action_type action;
   flags_type  flags;
   logic       accept;
   logic       rsp_drop;
   logic       link_shape;

   // input transfer
   assign accept = start && !busy;

   gdft_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .flags  (flags),
      .action (action),
      .busy   (busy)
   );

   gdft_path #(
      .VERTEX_COUNT     (VERTEX_COUNT),
      .EDGES_PER_VERTEX (EDGES_PER_VERTEX)
   ) u_path (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .action    (action),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // dropped link results carry no vertex and close the item
   assign rsp_drop   = rsp_valid && (rsp_data.status == STATUS_DROP);
   assign link_shape = (rsp_data.visited_vertex == '0) && rsp_data.last;

   // checks
   `GDFT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `GDFT_ASSERT_IMP(a_last_idle, clock, reset, rsp_valid && rsp_data.last, !busy)
   `GDFT_ASSERT_IMP(a_more_busy, clock, reset, rsp_valid && !rsp_data.last, busy)
   `GDFT_ASSERT_IMP(a_drop_zero, clock, reset, rsp_drop, link_shape)

endmodule
